### rtl/core/bsr_pkg.sv
`default_nettype none
package bsr_pkg;

   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 32;
   localparam int CNT_W   = 7;

   // storage port strobes from the controller
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } win_ctl_type;

endpackage
`default_nettype wire

### rtl/core/bsr_if.sv
`default_nettype none
interface bsr_req_if
   import bsr_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  data_byte;
   logic [INDEX_W-1:0] byte_index;
   logic               has_byte;
   logic               segment_end;
   logic               eof_flag;
   logic [CNT_W-1:0]   downstream_held;

   modport source (output valid, data_byte, byte_index, has_byte, segment_end,
                   eof_flag, downstream_held, input ready);
   modport sink   (input valid, data_byte, byte_index, has_byte, segment_end,
                   eof_flag, downstream_held, output ready);
endinterface

interface bsr_rsp_if
   import bsr_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              out_valid;
   logic              run_last;
   logic              stream_ended;
   logic [CNT_W-1:0]  pending_bytes;

   modport source (output valid, out_byte, out_valid, run_last, stream_ended,
                   pending_bytes, input ready);
   modport sink   (input valid, out_byte, out_valid, run_last, stream_ended,
                   pending_bytes, output ready);
endinterface
`default_nettype wire

### rtl/core/byte_stream_reassembler.sv
// Byte stream reassembler: each req transaction carries one segment byte with its
// 32-bit stream index; bytes inside the free window (CAPACITY minus downstream_held
// positions past the assembled point) are kept in a circular byte memory, stale,
// duplicate and out-of-window bytes are dropped. Every transaction yields one or
// more rsp transactions: one per newly assembled in-order byte, or a single
// status-only transaction, the last one marked by run_last. A transaction that
// assembles bytes runs a one-entry-per-cycle scan of the valid flags followed by
// one memory read per emitted byte. Only one transaction is in flight at a time.
// No clearing pass is needed after reset.
`default_nettype none
module byte_stream_reassembler
   import bsr_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  wire logic clock,
   input  wire logic reset,
   bsr_req_if.sink   req_if,
   bsr_rsp_if.source rsp_if
);
   localparam int IDX_W = $clog2(CAPACITY);

   win_ctl_type       win_ctl;
   logic [IDX_W-1:0]  wr_slot, rd_slot, chk_slot;
   logic [BYTE_W-1:0] wr_data, rd_data;
   logic              chk_valid;

   bsr_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .win_ctl   (win_ctl),
      .wr_slot   (wr_slot),
      .wr_data   (wr_data),
      .rd_slot   (rd_slot),
      .chk_slot  (chk_slot),
      .chk_valid (chk_valid),
      .rd_data   (rd_data)
   );

   bsr_window #(.CAPACITY(CAPACITY)) u_window (
      .clock     (clock),
      .reset     (reset),
      .ctl       (win_ctl),
      .wr_slot   (wr_slot),
      .wr_data   (wr_data),
      .rd_slot   (rd_slot),
      .chk_slot  (chk_slot),
      .chk_valid (chk_valid),
      .rd_data   (rd_data)
   );
endmodule
`default_nettype wire

### rtl/core/bsr_window.sv
`default_nettype none
module bsr_window
   import bsr_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire win_ctl_type                 ctl,
   input  wire logic [$clog2(CAPACITY)-1:0] wr_slot,
   input  wire logic [BYTE_W-1:0]           wr_data,
   input  wire logic [$clog2(CAPACITY)-1:0] rd_slot,
   input  wire logic [$clog2(CAPACITY)-1:0] chk_slot,
   output logic                             chk_valid,
   output logic [BYTE_W-1:0]                rd_data
);
   logic [BYTE_W-1:0] mem [CAPACITY];
   logic [CAPACITY-1:0] vld_ff;
   logic [BYTE_W-1:0]   rd_data_ff;

   assign chk_valid = vld_ff[chk_slot];
   assign rd_data   = rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_slot] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_slot];
      end
   end

   // a slot is filled on write and freed when it is read out
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (ctl.wr_en) vld_ff[wr_slot] <= 1'b1;
         if (ctl.rd_en) vld_ff[rd_slot] <= 1'b0;
      end
   end
endmodule
`default_nettype wire

### rtl/core/bsr_ctrl.sv
`default_nettype none
module bsr_ctrl
   import bsr_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   bsr_req_if.sink                          req_if,
   bsr_rsp_if.source                        rsp_if,
   output win_ctl_type                      win_ctl,
   output logic [$clog2(CAPACITY)-1:0]      wr_slot,
   output logic [BYTE_W-1:0]                wr_data,
   output logic [$clog2(CAPACITY)-1:0]      rd_slot,
   output logic [$clog2(CAPACITY)-1:0]      chk_slot,
   input  wire logic                        chk_valid,
   input  wire logic [BYTE_W-1:0]           rd_data
);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
   localparam logic [IDX_W:0]   CAP_S = (IDX_W+1)'(CAPACITY);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_STATUS} state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [IDX_W-1:0]   scan_ff, scan_in;
   logic [INDEX_W-1:0] next_exp_ff, next_exp_in;
   logic [CNT_W-1:0]   pending_ff, pending_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               eof_pend_ff, eof_pend_in;
   logic               trunc_ff, trunc_in;
   logic               ended_ff, ended_in;
   logic               rsp_vld_ff, rsp_vld_in;
   logic [BYTE_W-1:0]  out_byte_ff, out_byte_in;
   logic               out_valid_ff, out_valid_in;
   logic               run_last_ff, run_last_in;
   logic               stream_ended_ff, stream_ended_in;
   logic [CNT_W-1:0]   pend_out_ff, pend_out_in;

   logic [INDEX_W-1:0] gap;
   logic [CNT_W-1:0]   room;
   logic               in_win, beyond, store, trunc_mid, seg_done, out_free;
   logic [IDX_W:0]     slot_sum;
   logic [IDX_W-1:0]   slot;
   logic [CNT_W-1:0]   pend_left;
   logic               end_now;

   function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] s);
      slot_inc = (s == IDX_W'(CAPACITY - 1)) ? '0 : s + 1'b1;
   endfunction

   always_comb begin
      gap      = req_if.byte_index - next_exp_ff;
      room     = (req_if.downstream_held >= CAP_C) ? '0 : CAP_C - req_if.downstream_held;
      in_win   = (gap[INDEX_W-1:CNT_W] == '0) && (gap[CNT_W-1:0] < room);
      beyond   = !gap[INDEX_W-1] && !in_win;
      slot_sum = {1'b0, head_ff} + {1'b0, gap[IDX_W-1:0]};
      slot     = (slot_sum >= CAP_S) ? IDX_W'(slot_sum - CAP_S) : slot_sum[IDX_W-1:0];
      chk_slot = (state_ff == ST_IDLE) ? slot : scan_ff;
      store    = !ended_ff && req_if.has_byte && in_win && !chk_valid;
      trunc_mid = trunc_ff | (!ended_ff && req_if.has_byte && beyond);
      seg_done = !req_if.has_byte || req_if.segment_end;
      pend_left = pending_ff - cnt_ff;
      end_now   = ended_ff | (eof_pend_ff && pending_ff == '0);
      out_free  = !rsp_vld_ff || rsp_if.ready;
   end

   assign wr_slot = slot;
   assign wr_data = req_if.data_byte;
   assign rd_slot = head_ff;
   assign req_if.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in        = state_ff;
      head_in         = head_ff;
      scan_in         = scan_ff;
      next_exp_in     = next_exp_ff;
      pending_in      = pending_ff;
      cnt_in          = cnt_ff;
      eof_pend_in     = eof_pend_ff;
      trunc_in        = trunc_ff;
      ended_in        = ended_ff;
      rsp_vld_in      = rsp_vld_ff && !rsp_if.ready;
      out_byte_in     = out_byte_ff;
      out_valid_in    = out_valid_ff;
      run_last_in     = run_last_ff;
      stream_ended_in = stream_ended_ff;
      pend_out_in     = pend_out_ff;
      win_ctl         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               win_ctl.wr_en = store;
               if (store) pending_in = pending_ff + 1'b1;
               if (seg_done) begin
                  if (req_if.eof_flag && !trunc_mid) eof_pend_in = 1'b1;
                  trunc_in = 1'b0;
               end else begin
                  trunc_in = trunc_mid;
               end
               // only a byte landing on the head can extend the assembled run
               if (store && gap[IDX_W-1:0] == '0) begin
                  scan_in  = head_ff;
                  cnt_in   = '0;
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_STATUS;
               end
            end
         end
         ST_SCAN: begin
            if (chk_valid && cnt_ff != CAP_C) begin
               cnt_in  = cnt_ff + 1'b1;
               scan_in = slot_inc(scan_ff);
            end else begin
               pending_in    = pend_left;
               ended_in      = ended_ff | (eof_pend_ff && pend_left == '0);
               win_ctl.rd_en = 1'b1;
               head_in       = slot_inc(head_ff);
               next_exp_in   = next_exp_ff + 1'b1;
               state_in      = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               rsp_vld_in      = 1'b1;
               out_byte_in     = rd_data;
               out_valid_in    = 1'b1;
               run_last_in     = (cnt_ff == CNT_W'(1));
               stream_ended_in = ended_ff;
               pend_out_in     = pending_ff;
               cnt_in          = cnt_ff - 1'b1;
               if (cnt_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  win_ctl.rd_en = 1'b1;
                  head_in       = slot_inc(head_ff);
                  next_exp_in   = next_exp_ff + 1'b1;
               end
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               rsp_vld_in      = 1'b1;
               out_byte_in     = '0;
               out_valid_in    = 1'b0;
               run_last_in     = 1'b1;
               stream_ended_in = end_now;
               pend_out_in     = pending_ff;
               ended_in        = end_now;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         head_ff     <= '0;
         next_exp_ff <= '0;
         pending_ff  <= '0;
         eof_pend_ff <= 1'b0;
         trunc_ff    <= 1'b0;
         ended_ff    <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         next_exp_ff <= next_exp_in;
         pending_ff  <= pending_in;
         eof_pend_ff <= eof_pend_in;
         trunc_ff    <= trunc_in;
         ended_ff    <= ended_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      scan_ff         <= scan_in;
      cnt_ff          <= cnt_in;
      out_byte_ff     <= out_byte_in;
      out_valid_ff    <= out_valid_in;
      run_last_ff     <= run_last_in;
      stream_ended_ff <= stream_ended_in;
      pend_out_ff     <= pend_out_in;
   end

   assign rsp_if.valid         = rsp_vld_ff;
   assign rsp_if.out_byte      = out_byte_ff;
   assign rsp_if.out_valid     = out_valid_ff;
   assign rsp_if.run_last      = run_last_ff;
   assign rsp_if.stream_ended  = stream_ended_ff;
   assign rsp_if.pending_bytes = pend_out_ff;
endmodule
`default_nettype wire

### test/tb_top.sv
module tb_top;
   import bsr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP         = 64;
   localparam int LONG_HOLD   = 400;
   localparam int DRAIN_WAIT  = 150;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic [BYTE_W-1:0]  data_byte;
      logic [INDEX_W-1:0] byte_index;
      logic               has_byte;
      logic               segment_end;
      logic               eof_flag;
      logic [CNT_W-1:0]   downstream_held;
   } seg_byte_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              out_valid;
      logic              run_last;
      logic              stream_ended;
      logic [CNT_W-1:0]  pending_bytes;
   } asm_out_type;

   typedef enum logic [1:0] {RCV_FREE, RCV_RANDOM, RCV_PATTERN, RCV_SLOW} rcv_mode_type;

   logic clock = 1'b0;
   logic reset;

   bsr_req_if req_bus ();
   bsr_rsp_if rsp_bus ();

   byte_stream_reassembler #(.CAPACITY(CAP)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // mirror of the reassembly window
   logic [BYTE_W-1:0]  win_data [CAP];
   logic               win_full [CAP];
   int                 win_head;
   logic [INDEX_W-1:0] asm_point;
   int                 held_count;
   logic               eof_seen;
   logic               seg_cut;
   logic               stream_done;

   asm_out_type out_expected [$];
   int          errors;
   int          cycle_count;

   rcv_mode_type rcv_mode;
   int        hold_asked;
   int        hold_taken;
   int        hold_left;
   int        rcv_tick;
   logic      gaps_on;
   int        burst_left;

   function automatic seg_byte_type make_byte(input logic [BYTE_W-1:0] data,
                                              input logic [INDEX_W-1:0] idx,
                                              input int has, input int seg_end,
                                              input int eof, input int held);
      seg_byte_type it;
      it.data_byte       = data;
      it.byte_index      = idx;
      it.has_byte        = has[0];
      it.segment_end     = seg_end[0];
      it.eof_flag        = eof[0];
      it.downstream_held = held[CNT_W-1:0];
      return it;
   endfunction

   function automatic void predict_reassembly(input seg_byte_type it);
      logic [INDEX_W-1:0] gap;
      int unsigned        room;
      int                 slot;
      logic [BYTE_W-1:0]  drained [$];
      asm_out_type        r;
      if (!stream_done && it.has_byte) begin
         gap = it.byte_index - asm_point;
         // top bit of the distance set means the byte lies behind the assembled point
         if (!gap[INDEX_W-1]) begin
            room = (it.downstream_held >= CAP) ? 0 : CAP - int'(it.downstream_held);
            if (gap < room) begin
               slot = (win_head + int'(gap)) % CAP;
               if (!win_full[slot]) begin
                  win_data[slot] = it.data_byte;
                  win_full[slot] = 1'b1;
                  held_count++;
               end
            end else begin
               seg_cut = 1'b1;
            end
         end
      end
      if (!it.has_byte || it.segment_end) begin
         if (it.eof_flag && !seg_cut)
            eof_seen = 1'b1;
         seg_cut = 1'b0;
      end
      while (win_full[win_head]) begin
         drained.push_back(win_data[win_head]);
         win_full[win_head] = 1'b0;
         win_head = (win_head + 1) % CAP;
         asm_point++;
         if (held_count > 0)
            held_count--;
      end
      if (eof_seen && held_count == 0)
         stream_done = 1'b1;
      r.stream_ended  = stream_done;
      r.pending_bytes = held_count[CNT_W-1:0];
      if (drained.size() == 0) begin
         r.out_byte  = '0;
         r.out_valid = 1'b0;
         r.run_last  = 1'b1;
         out_expected.push_back(r);
      end else begin
         foreach (drained[k]) begin
            r.out_byte  = drained[k];
            r.out_valid = 1'b1;
            r.run_last  = (k == drained.size() - 1);
            out_expected.push_back(r);
         end
      end
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      asm_out_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (out_expected.size() == 0) begin
            $error("unexpected rsp transaction: out_byte %0h out_valid %0b",
                   rsp_bus.out_byte, rsp_bus.out_valid);
            errors++;
         end else begin
            want = out_expected[0];
            out_expected.delete(0);
            check_field("out_byte", 32'(want.out_byte), 32'(rsp_bus.out_byte));
            check_field("out_valid", 32'(want.out_valid), 32'(rsp_bus.out_valid));
            check_field("run_last", 32'(want.run_last), 32'(rsp_bus.run_last));
            check_field("stream_ended", 32'(want.stream_ended),
                        32'(rsp_bus.stream_ended));
            check_field("pending_bytes", 32'(want.pending_bytes),
                        32'(rsp_bus.pending_bytes));
         end
      end
   end

   // receiver: stall pattern per mode, plus long hold-offs on request
   initial begin
      rsp_bus.ready = 1'b0;
      hold_taken = 0;
      hold_left = 0;
      rcv_tick = 0;
      forever begin
         @(negedge clock);
         rcv_tick++;
         if (hold_taken != hold_asked) begin
            hold_taken++;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready = 1'b0;
         end else begin
            case (rcv_mode)
               RCV_FREE:    rsp_bus.ready = 1'b1;
               RCV_RANDOM:  rsp_bus.ready = ($urandom_range(0, 3) != 0);
               RCV_PATTERN: rsp_bus.ready = ((rcv_tick % 7) >= 3);
               default:     rsp_bus.ready = ($urandom_range(0, 5) == 0);
            endcase
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   task automatic send_item(input seg_byte_type it);
      @(negedge clock);
      req_bus.valid           = 1'b1;
      req_bus.data_byte       = it.data_byte;
      req_bus.byte_index      = it.byte_index;
      req_bus.has_byte        = it.has_byte;
      req_bus.segment_end     = it.segment_end;
      req_bus.eof_flag        = it.eof_flag;
      req_bus.downstream_held = it.downstream_held;
      @(posedge clock);
      while (req_bus.ready !== 1'b1)
         @(posedge clock);
      predict_reassembly(it);
   endtask

   task automatic idle_for(input int n);
      @(negedge clock);
      req_bus.valid = 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic offer(input seg_byte_type it);
      if (gaps_on) begin
         if (burst_left == 0) begin
            idle_for($urandom_range(1, 10));
            burst_left = $urandom_range(1, 12);
         end
         burst_left--;
      end
      send_item(it);
   endtask

   task automatic pause_until_drained();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (out_expected.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_directed_cases();
      offer(make_byte(8'hFF, asm_point, 1, 1, 0, 0));
      offer(make_byte(8'h00, asm_point + 1, 1, 1, 0, 0));
      offer(make_byte(8'h5A, asm_point + 1, 1, 1, 0, 0));     // duplicate
      offer(make_byte(8'h11, asm_point - 1, 1, 1, 0, 0));     // stale
      offer(make_byte(8'hA5, asm_point, 1, 1, 0, 0));         // closes the hole
      offer(make_byte(8'h3C, asm_point, 1, 0, 0, 64));        // downstream full
      offer(make_byte(8'hC3, asm_point, 1, 1, 1, 63));        // eof lost to truncation
      offer(make_byte(8'h55, asm_point + 54, 1, 0, 0, 10));   // just past free window
      offer(make_byte(8'hAA, asm_point + 53, 1, 1, 0, 10));   // last free slot
      offer(make_byte(8'h01, 32'hFFFF_FFFF, 1, 0, 0, 0));
      offer(make_byte(8'h02, 32'h7FFF_FFFF, 1, 0, 0, 0));
      offer(make_byte(8'h03, 32'h0, 0, 0, 0, 0));             // empty segment
      offer(make_byte(8'h80, asm_point + CAP - 1, 1, 1, 0, 0));
      offer(make_byte(8'h7F, asm_point, 1, 1, 0, 0));
      offer(make_byte(8'h04, asm_point + 32'h7FFF_FFFF, 1, 0, 0, 0));
      offer(make_byte(8'h08, asm_point + 32'h8000_0000, 1, 1, 0, 0));
      offer(make_byte(8'h10, asm_point + 3, 1, 0, 0, 61));
      offer(make_byte(8'h20, asm_point + 2, 1, 1, 1, 61));
      offer(make_byte(8'h40, asm_point, 0, 1, 0, 0));
      pause_until_drained();
   endtask

   // fill the whole window out of order, then release it with one transaction
   task automatic test_full_window();
      logic [INDEX_W-1:0] base;
      int                 offs [CAP-1];
      int                 j;
      int                 t;
      base = asm_point;
      foreach (offs[i])
         offs[i] = i + 1;
      for (int i = CAP - 2; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = offs[i];
         offs[i] = offs[j];
         offs[j] = t;
      end
      rcv_mode = RCV_FREE;
      gaps_on = 1'b0;
      hold_asked++;
      foreach (offs[i])
         offer(make_byte(BYTE_W'($urandom_range(0, 255)), base + offs[i], 1, 1, 0, 0));
      offer(make_byte(BYTE_W'($urandom_range(0, 255)), base, 1, 1, 0, 0));
      pause_until_drained();
   endtask

   task automatic test_random_traffic(input int n_items);
      int                 sent;
      int                 next_phase;
      int                 kind;
      int                 len;
      int                 held;
      int                 has;
      int                 seg_end;
      logic [INDEX_W-1:0] base;
      sent = 0;
      next_phase = 0;
      while (sent < n_items) begin
         if (sent >= next_phase) begin
            if (next_phase % 120 == 0 && next_phase != 0)
               pause_until_drained();
            rcv_mode = rcv_mode_type'($urandom_range(0, 3));
            gaps_on = ($urandom_range(0, 2) != 0);
            next_phase += 40;
         end
         kind = $urandom_range(0, 99);
         if (kind < 10) begin
            has = $urandom_range(0, 1);
            seg_end = $urandom_range(0, 1);
            // eof only where the block ignores it, so the stream stays open
            offer(make_byte(BYTE_W'($urandom_range(0, 255)), $urandom, has, seg_end,
                            (has != 0 && seg_end == 0) ? $urandom_range(0, 1) : 0,
                            $urandom_range(0, 64)));
            sent++;
         end else if (kind < 18) begin
            len = $urandom_range(1, 3);
            base = asm_point - $urandom_range(1, 8);
            for (int k = 0; k < len; k++)
               offer(make_byte(BYTE_W'($urandom_range(0, 255)), base + k, 1,
                               int'(k == len - 1), 0, $urandom_range(0, 12)));
            sent += len;
         end else if (kind < 22) begin
            offer(make_byte(BYTE_W'($urandom_range(0, 255)), $urandom, 0,
                            $urandom_range(0, 1), 0, $urandom_range(0, 64)));
            sent++;
         end else begin
            len = $urandom_range(1, 10);
            base = asm_point + (($urandom_range(0, 1) == 1) ? 0 : $urandom_range(1, 24));
            held = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 64) : $urandom_range(0, 12);
            for (int k = 0; k < len; k++)
               offer(make_byte(BYTE_W'($urandom_range(0, 255)), base + k, 1,
                               int'(k == len - 1), 0, held));
            sent += len;
         end
      end
      pause_until_drained();
   endtask

   task automatic test_stream_end();
      rcv_mode = RCV_RANDOM;
      gaps_on = 1'b1;
      offer(make_byte(8'h00, 32'h0, 0, 1, 0, 0));
      offer(make_byte(BYTE_W'($urandom_range(0, 255)), asm_point + 1, 1, 1, 0, 0));
      // empty segment without segment_end still completes and latches eof
      offer(make_byte(8'h00, 32'h0, 0, 0, 1, 0));
      while (!stream_done)
         offer(make_byte(BYTE_W'($urandom_range(0, 255)), asm_point, 1, 1, 0,
                         $urandom_range(0, 8)));
      offer(make_byte(BYTE_W'($urandom_range(0, 255)), asm_point, 1, 1, 0, 0));
      offer(make_byte(BYTE_W'($urandom_range(0, 255)), asm_point + 1, 1, 0, 1, 0));
      offer(make_byte(8'h00, 32'h0, 0, 1, 1, 0));
      offer(make_byte(BYTE_W'($urandom_range(0, 255)), $urandom, 1, 1, 0, 64));
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid           = 1'b0;
      req_bus.data_byte       = '0;
      req_bus.byte_index      = '0;
      req_bus.has_byte        = 1'b0;
      req_bus.segment_end     = 1'b0;
      req_bus.eof_flag        = 1'b0;
      req_bus.downstream_held = '0;
      foreach (win_full[i]) begin
         win_full[i] = 1'b0;
         win_data[i] = '0;
      end
      win_head    = 0;
      asm_point   = '0;
      held_count  = 0;
      eof_seen    = 1'b0;
      seg_cut     = 1'b0;
      stream_done = 1'b0;
      errors      = 0;
      rcv_mode    = RCV_RANDOM;
      hold_asked  = 0;
      gaps_on     = 1'b1;
      burst_left  = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_full_window();
      test_random_traffic(310);
      test_stream_end();

      @(negedge clock);
      req_bus.valid = 1'b0;
      while (out_expected.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

### sim.f
rtl/core/bsr_pkg.sv
rtl/core/bsr_if.sv
rtl/core/bsr_window.sv
rtl/core/bsr_ctrl.sv
rtl/core/byte_stream_reassembler.sv
test/tb_top.sv
